// ===== hw/rtl/ttgm_pkg.sv =====
// Shared types, field widths and helpers for the touch tap gesture to mouse unit.
// Used by the top level and by its port checker; depends on nothing else.
package ttgm_pkg;

  // field widths
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned PX_W     = 12;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned ACC_W    = 16;
  localparam int unsigned STEP_W   = 8;
  localparam int unsigned FCNT_W   = 4;
  localparam int unsigned TAP_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // packed stream widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 72;

  // reset values of the configuration registers
  localparam logic [SIZE_W-1:0] SCREEN_W_RST    = 13'd640;
  localparam logic [SIZE_W-1:0] SCREEN_H_RST    = 13'd480;
  localparam logic [MS_W-1:0]   RELEASE_WAIT_RST = 16'd150;
  localparam logic [MS_W-1:0]   TAP_GAP_RST      = 16'd250;

  localparam logic [PX_W-1:0]   PX_MAX   = 12'd4095;
  localparam logic [FCNT_W-1:0] FCNT_MAX = 4'd15;
  localparam logic [TAP_W-1:0]  TAP_MAX  = 8'd255;

  typedef enum logic [2:0] {
    ACT_DOWN   = 3'd0,
    ACT_MOTION = 3'd1,
    ACT_UP     = 3'd2,
    ACT_WHEEL  = 3'd3,
    ACT_MOUSE  = 3'd4,
    ACT_POLL   = 3'd5
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_W     = 2'd0,
    REG_SCREEN_H     = 2'd1,
    REG_RELEASE_WAIT = 2'd2,
    REG_TAP_GAP      = 2'd3
  } cfg_reg_t;

  // pixel from 13-bit scaled product top, clamped to the pixel range
  function automatic logic [PX_W-1:0] px_clamp(input logic [SIZE_W-1:0] p);
    return p[SIZE_W-1] ? PX_MAX : p[PX_W-1:0];
  endfunction

  // 16-bit signed accumulate with saturation, delta up to 18 bits signed
  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] acc,
    input logic signed [17:0]      delta
  );
    logic signed [17:0] sum;
    sum = 18'(acc) + delta;
    if (sum > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (sum < -18'sd32768) begin
      return 16'sh8000;
    end
    return sum[ACC_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/touch_tap_gesture_to_mouse_unit.sv =====
// Touch tap gesture to mouse unit: finger and mouse items in, mouse reports out; uses ttgm_pkg.
// Path: a poll item's report passes the input register, which holds the scaled pixels,
// and then the state update and report register before it is offered.
// Throughput: one item per cycle; a poll waits in the input stage only while a
// report is held in the output register and not taken.
// Reset: synchronous active-low rst_n clears valids and gesture state; loads config defaults.
module touch_tap_gesture_to_mouse_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata from bit 0: touch_x[16], touch_y[16], time_ms[32], wheel_step_x[8],
  // wheel_step_y[8], mouse_dx[16], mouse_dy[16], mouse_left, mouse_right, pad[6]
  input  logic [ttgm_pkg::IN_DATA_W-1:0]       in_tdata,
  // tuser: action[3]
  input  logic [2:0]                           in_tuser,
  // report stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // tdata from bit 0: report_dx[16], report_dy[16], left_click, right_click,
  // report_wheel_x[16], report_wheel_y[16], pad[6]
  output logic [ttgm_pkg::OUT_DATA_W-1:0]      out_tdata,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ttgm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ttgm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ttgm_pkg::*;

  // configuration registers
  logic [SIZE_W-1:0] screen_w_r, screen_h_r;
  logic [MS_W-1:0]   release_wait_r, tap_gap_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r     <= SCREEN_W_RST;
      screen_h_r     <= SCREEN_H_RST;
      release_wait_r <= RELEASE_WAIT_RST;
      tap_gap_r      <= TAP_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCREEN_W:     screen_w_r     <= cfg_data[SIZE_W-1:0];
        REG_SCREEN_H:     screen_h_r     <= cfg_data[SIZE_W-1:0];
        REG_RELEASE_WAIT: release_wait_r <= cfg_data[MS_W-1:0];
        REG_TAP_GAP:      tap_gap_r      <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // input field unpack
  logic [FRAC_W-1:0] in_touch_x, in_touch_y;
  assign in_touch_x = in_tdata[15:0];
  assign in_touch_y = in_tdata[31:16];

  // pixel scaling ahead of the input register
  logic [FRAC_W+SIZE_W-1:0] prod_x, prod_y;
  assign prod_x = (FRAC_W+SIZE_W)'(in_touch_x) * (FRAC_W+SIZE_W)'(screen_w_r);
  assign prod_y = (FRAC_W+SIZE_W)'(in_touch_y) * (FRAC_W+SIZE_W)'(screen_h_r);

  // input stage register
  logic                     s1_valid_r;
  logic [2:0]               s1_action_r;
  logic [PX_W-1:0]          s1_px_x_r, s1_px_y_r;
  logic [TIME_W-1:0]        s1_time_r;
  logic signed [STEP_W-1:0] s1_step_x_r, s1_step_y_r;
  logic [ACC_W-1:0]         s1_mdx_r, s1_mdy_r;
  logic                     s1_mleft_r, s1_mright_r;

  logic s1_poll, out_free, s1_adv;
  assign s1_poll   = (action_t'(s1_action_r) == ACT_POLL);
  assign out_free  = !out_tvalid || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_poll || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_action_r <= in_tuser;
      s1_px_x_r   <= px_clamp(prod_x[FRAC_W+SIZE_W-1:FRAC_W]);
      s1_px_y_r   <= px_clamp(prod_y[FRAC_W+SIZE_W-1:FRAC_W]);
      s1_time_r   <= in_tdata[63:32];
      s1_step_x_r <= in_tdata[71:64];
      s1_step_y_r <= in_tdata[79:72];
      s1_mdx_r    <= in_tdata[95:80];
      s1_mdy_r    <= in_tdata[111:96];
      s1_mleft_r  <= in_tdata[112];
      s1_mright_r <= in_tdata[113];
    end
  end

  // gesture state
  logic                    touch_mode_r, touch_mode_nxt;
  logic [PX_W-1:0]         last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  logic signed [ACC_W-1:0] acc_dx_r, acc_dx_nxt, acc_dy_r, acc_dy_nxt;
  logic [FCNT_W-1:0]       fcnt_r, fcnt_nxt;
  logic [TIME_W-1:0]       down_t_r, down_t_nxt, up_t_r, up_t_nxt;
  logic [TAP_W-1:0]        taps_r, taps_nxt;
  logic                    done_r, done_nxt;
  logic signed [ACC_W-1:0] wheel_x_r, wheel_x_nxt, wheel_y_r, wheel_y_nxt;

  // report register
  logic                    out_valid_r, out_valid_nxt;
  logic [ACC_W-1:0]        rep_dx_r, rep_dx_nxt, rep_dy_r, rep_dy_nxt;
  logic                    rep_left_r, rep_left_nxt, rep_right_r, rep_right_nxt;
  logic [ACC_W-1:0]        rep_wx_r, rep_wx_nxt, rep_wy_r, rep_wy_nxt;

  // motion deltas and elapsed times
  logic signed [PX_W:0]  dlt_x, dlt_y;
  logic [TIME_W-1:0]     since_down, since_up;
  logic                  gap_over, wait_down, wait_up;

  assign dlt_x      = $signed({1'b0, s1_px_x_r}) - $signed({1'b0, last_x_r});
  assign dlt_y      = $signed({1'b0, s1_px_y_r}) - $signed({1'b0, last_y_r});
  assign since_down = s1_time_r - down_t_r;
  assign since_up   = s1_time_r - up_t_r;
  assign gap_over   = since_down > {16'd0, tap_gap_r};
  assign wait_down  = since_down > {16'd0, release_wait_r};
  assign wait_up    = since_up > {16'd0, release_wait_r};

  always_comb begin
    touch_mode_nxt = touch_mode_r;
    last_x_nxt     = last_x_r;
    last_y_nxt     = last_y_r;
    acc_dx_nxt     = acc_dx_r;
    acc_dy_nxt     = acc_dy_r;
    fcnt_nxt       = fcnt_r;
    down_t_nxt     = down_t_r;
    up_t_nxt       = up_t_r;
    taps_nxt       = taps_r;
    done_nxt       = done_r;
    wheel_x_nxt    = wheel_x_r;
    wheel_y_nxt    = wheel_y_r;
    rep_dx_nxt     = rep_dx_r;
    rep_dy_nxt     = rep_dy_r;
    rep_left_nxt   = rep_left_r;
    rep_right_nxt  = rep_right_r;
    rep_wx_nxt     = rep_wx_r;
    rep_wy_nxt     = rep_wy_r;
    out_valid_nxt  = out_valid_r && !out_tready;

    if (s1_adv) begin
      unique case (action_t'(s1_action_r)) inside
        ACT_DOWN: begin
          if (fcnt_r != FCNT_MAX) fcnt_nxt = fcnt_r + 4'd1;
          last_x_nxt = s1_px_x_r;
          last_y_nxt = s1_px_y_r;
          acc_dx_nxt = '0;
          acc_dy_nxt = '0;
          if (gap_over) begin
            taps_nxt = '0;
            done_nxt = 1'b0;
          end
          down_t_nxt     = s1_time_r;
          touch_mode_nxt = 1'b1;
        end
        ACT_MOTION, ACT_UP: begin
          acc_dx_nxt = sat_add(acc_dx_r, 18'(dlt_x));
          acc_dy_nxt = sat_add(acc_dy_r, 18'(dlt_y));
          last_x_nxt = s1_px_x_r;
          last_y_nxt = s1_px_y_r;
          if (action_t'(s1_action_r) == ACT_UP) begin
            if (fcnt_r != '0) fcnt_nxt = fcnt_r - 4'd1;
            if (taps_r != TAP_MAX) taps_nxt = taps_r + 8'd1;
            up_t_nxt = s1_time_r;
          end
          touch_mode_nxt = 1'b1;
        end
        ACT_WHEEL, ACT_MOUSE: begin
          if (action_t'(s1_action_r) == ACT_WHEEL) begin
            wheel_x_nxt = sat_add(wheel_x_r, 18'(s1_step_x_r));
            wheel_y_nxt = sat_add(wheel_y_r, 18'(s1_step_y_r));
          end
          // leaving touch mode drops the whole touch state
          if (touch_mode_r) begin
            last_x_nxt     = '0;
            last_y_nxt     = '0;
            acc_dx_nxt     = '0;
            acc_dy_nxt     = '0;
            fcnt_nxt       = '0;
            down_t_nxt     = '0;
            up_t_nxt       = '0;
            taps_nxt       = '0;
            done_nxt       = 1'b0;
            touch_mode_nxt = 1'b0;
          end
        end
        ACT_POLL: begin
          out_valid_nxt = 1'b1;
          if (touch_mode_r) begin
            rep_dx_nxt    = acc_dx_r;
            rep_dy_nxt    = acc_dy_r;
            acc_dx_nxt    = '0;
            acc_dy_nxt    = '0;
            rep_left_nxt  = 1'b0;
            rep_right_nxt = 1'b0;
            rep_wx_nxt    = '0;
            rep_wy_nxt    = '0;
            // no finger down: double tap is left, triple tap is right
            if (fcnt_r == 4'd0) begin
              if (wait_up && !done_r) begin
                if (taps_r == 8'd2) begin
                  rep_left_nxt = 1'b1;
                  done_nxt     = 1'b1;
                end else if (taps_r == 8'd3) begin
                  rep_right_nxt = 1'b1;
                  done_nxt      = 1'b1;
                end
              end
            // one finger held: tap-and-hold is left, double tap-and-hold is right
            end else if (fcnt_r == 4'd1) begin
              if (wait_down) begin
                if (taps_r == 8'd1) begin
                  rep_left_nxt = 1'b1;
                  done_nxt     = 1'b1;
                end else if (taps_r == 8'd2) begin
                  rep_right_nxt = 1'b1;
                  done_nxt      = 1'b1;
                end
              end
            end
          end else begin
            rep_dx_nxt    = s1_mdx_r;
            rep_dy_nxt    = s1_mdy_r;
            rep_left_nxt  = s1_mleft_r;
            rep_right_nxt = s1_mright_r;
            rep_wx_nxt    = wheel_x_r;
            rep_wy_nxt    = wheel_y_r;
            wheel_x_nxt   = '0;
            wheel_y_nxt   = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // state and report registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touch_mode_r <= 1'b0;
      last_x_r     <= '0;
      last_y_r     <= '0;
      acc_dx_r     <= '0;
      acc_dy_r     <= '0;
      fcnt_r       <= '0;
      down_t_r     <= '0;
      up_t_r       <= '0;
      taps_r       <= '0;
      done_r       <= 1'b0;
      wheel_x_r    <= '0;
      wheel_y_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      touch_mode_r <= touch_mode_nxt;
      last_x_r     <= last_x_nxt;
      last_y_r     <= last_y_nxt;
      acc_dx_r     <= acc_dx_nxt;
      acc_dy_r     <= acc_dy_nxt;
      fcnt_r       <= fcnt_nxt;
      down_t_r     <= down_t_nxt;
      up_t_r       <= up_t_nxt;
      taps_r       <= taps_nxt;
      done_r       <= done_nxt;
      wheel_x_r    <= wheel_x_nxt;
      wheel_y_r    <= wheel_y_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rep_dx_r    <= rep_dx_nxt;
    rep_dy_r    <= rep_dy_nxt;
    rep_left_r  <= rep_left_nxt;
    rep_right_r <= rep_right_nxt;
    rep_wx_r    <= rep_wx_nxt;
    rep_wy_r    <= rep_wy_nxt;
  end

  // report pack
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, rep_wy_r, rep_wx_r, rep_right_r, rep_left_r, rep_dy_r, rep_dx_r};

endmodule

// ===== hw/rtl/ttgm_checker.sv =====
// Port-level checker for the touch tap gesture to mouse unit, with its bind.
// Depends on ttgm_pkg; watches the top level's ports only.
module ttgm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ttgm_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import ttgm_pkg::*;

  // a held report stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("report withdrawn while stalled");

  // a held report keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("report data changed while stalled");

  // reset leaves no report pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("report pending after reset");

  // a fresh report follows an accepted item through the input register and the report register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("report without an item two cycles earlier");

  // the input only stalls behind a report that is not taken
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled with the report side free");

endmodule

bind touch_tap_gesture_to_mouse_unit ttgm_checker u_ttgm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
